/* rtl/buffer_pool_ownership_manager_core_assert.svh */
// ---------------------------------------------------------------------------
// Buffer pool ownership manager - assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef BUFFER_POOL_OWNERSHIP_MANAGER_CORE_ASSERT_SVH
`define BUFFER_POOL_OWNERSHIP_MANAGER_CORE_ASSERT_SVH

// same-cycle implication
`define BPOM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPOM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bpom_pkg.sv */
// ---------------------------------------------------------------------------
// bpom_pkg
// Shared types and codes of the buffer pool ownership manager.
// ---------------------------------------------------------------------------
package bpom_pkg;

	localparam int NUM_BUFFERS_DEF = 16;
	localparam int ID_W            = 8;
	localparam int MODE_W          = 3;
	localparam int STATUS_W        = 3;
	localparam int CNT_W           = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_PROD_ACQ = 3'd0,
		MODE_COMMIT   = 3'd1,
		MODE_CANCEL   = 3'd2,
		MODE_CONS_ACQ = 3'd3,
		MODE_CONS_REL = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_FREE  = 3'd1,
		ST_NO_READY = 3'd2,
		ST_BAD_BUF  = 3'd3,
		ST_BAD_MODE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MARK_NONE = 2'd0,
		MARK_PROD = 2'd1,
		MARK_CONS = 2'd2
	} mark_t;

	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
	} q_ctl_t;

endpackage

/* rtl/bpom_if.sv */
// ---------------------------------------------------------------------------
// bpom_req_if / bpom_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface bpom_req_if
	import bpom_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0]   buffer_id;

	modport source (output valid, output mode, output buffer_id, input ready);
	modport sink   (input valid, input mode, input buffer_id, output ready);
endinterface

interface bpom_rsp_if
	import bpom_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     granted_id;
	logic [CNT_W-1:0]    free_count;
	logic [CNT_W-1:0]    ready_count;

	modport source (output valid, output status, output granted_id,
		output free_count, output ready_count, input ready);
	modport sink   (input valid, input status, input granted_id,
		input free_count, input ready_count, output ready);
endinterface

/* rtl/bpom_queue.sv */
// ---------------------------------------------------------------------------
// bpom_queue
// Circular id queue over a synchronous RAM, registered read of the head
// slot, push to the tail. Optional fill with ids 0..N-1 at start.
// ---------------------------------------------------------------------------
module bpom_queue
	import bpom_pkg::*;
#(
	parameter int N         = NUM_BUFFERS_DEF,
	parameter int IW        = 4,
	parameter int CW        = 5,
	parameter bit INIT_FULL = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            init_we,
	input  logic [IW-1:0]   init_addr,
	input  q_ctl_t          ctl,
	input  logic [ID_W-1:0] push_id,
	output logic [ID_W-1:0] rd_data,
	output logic [CW-1:0]   fill,
	output logic            empty,
	output logic            full
);

	localparam int SW = CW + 1;

	logic [ID_W-1:0] mem [N];
	logic [ID_W-1:0] rd_data_q;
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   fill_q;
	logic [SW-1:0]   tail_sum;
	logic [SW-1:0]   tail_wrap;
	logic            push_ok;
	logic            pop_ok;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic [ID_W-1:0] wr_data;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == CW'(N));
	assign push_ok = ctl.push && !full;
	assign pop_ok  = ctl.pop && !empty;

	assign tail_sum  = SW'(head_q) + SW'(fill_q);
	assign tail_wrap = (tail_sum >= SW'(N)) ? (tail_sum - SW'(N)) : tail_sum;

	always_comb begin
		if (INIT_FULL && init_we) begin
			wr_en   = 1'b1;
			wr_addr = init_addr;
			wr_data = ID_W'(init_addr);
		end else begin
			wr_en   = push_ok;
			wr_addr = tail_wrap[IW-1:0];
			wr_data = push_id;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (ctl.rd)
			rd_data_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= INIT_FULL ? CW'(N) : '0;
		end else begin
			if (pop_ok)
				head_q <= (head_q == IW'(N - 1)) ? '0 : head_q + 1'b1;
			fill_q <= fill_q + CW'(push_ok) - CW'(pop_ok);
		end
	end

	assign rd_data = rd_data_q;
	assign fill    = fill_q;

endmodule

/* rtl/bpom_mark_mem.sv */
// ---------------------------------------------------------------------------
// bpom_mark_mem
// Lock mark per buffer id: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bpom_mark_mem
	import bpom_pkg::*;
#(
	parameter int N  = NUM_BUFFERS_DEF,
	parameter int IW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  mark_t         wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output mark_t         rdata
);

	mark_t mem [N];
	mark_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/buffer_pool_ownership_manager_core.sv */
// ---------------------------------------------------------------------------
// buffer_pool_ownership_manager_core
// Hands buffer ids between a free queue, a ready queue and per-id lock
// marks held in RAM.
// ---------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   mode, buffer_id
//  rsp      out  status, granted_id, free_count, ready_count
//
//  Per request: the accept edge reads queue heads and the lock mark; in
//  S_EXEC, once the result register is free or being taken, the write-back
//  and the load of the result register follow. The RAM read comes ahead of
//  the write-back; requests never overlap, so no forwarding is needed.
//  After reset a sweep over all NUM_BUFFERS ids loads the free queue and
//  clears the marks; req.ready stays low meanwhile.
//  A held result stalls the write-back of the following request.
// ---------------------------------------------------------------------------
module buffer_pool_ownership_manager_core
	import bpom_pkg::*;
#(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bpom_req_if.sink    req,
	bpom_rsp_if.source  rsp
);

`include "buffer_pool_ownership_manager_core_assert.svh"

	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW = $clog2(NUM_BUFFERS + 1);

	typedef enum logic [2:0] {
		S_INIT = 3'b001,
		S_IDLE = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       init_cnt_q;
	logic [MODE_W-1:0]   mode_s1;
	logic [ID_W-1:0]     id_s1;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     granted_q;
	logic [CNT_W-1:0]    free_cnt_q;
	logic [CNT_W-1:0]    ready_cnt_q;

	logic                acc;
	logic                go;
	logic                in_init;
	logic                in_pool;
	logic [IW-1:0]       idx;

	q_ctl_t              free_ctl;
	q_ctl_t              ready_ctl;
	logic [ID_W-1:0]     free_rd;
	logic [ID_W-1:0]     ready_rd;
	logic [CW-1:0]       free_fill;
	logic [CW-1:0]       ready_fill;
	logic                free_empty;
	logic                free_full;
	logic                ready_empty;
	logic                ready_full;

	mark_t               mark_rd;
	logic                mark_we;
	logic [IW-1:0]       mark_waddr;
	mark_t               mark_wdata;

	logic                x_pop_free;
	logic                x_pop_ready;
	logic                x_push_free;
	logic                x_push_ready;
	logic                x_mark_we;
	logic [IW-1:0]       x_mark_addr;
	mark_t               x_mark_val;
	status_t             x_status;
	logic [ID_W-1:0]     x_granted;
	logic [CW-1:0]       free_nxt;
	logic [CW-1:0]       ready_nxt;

	assign in_init   = (state_q == S_INIT);
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign go        = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	assign in_pool = ({1'b0, id_s1} < (ID_W + 1)'(NUM_BUFFERS));
	assign idx     = id_s1[IW-1:0];

	always_comb begin
		x_pop_free   = 1'b0;
		x_pop_ready  = 1'b0;
		x_push_free  = 1'b0;
		x_push_ready = 1'b0;
		x_mark_we    = 1'b0;
		x_mark_addr  = idx;
		x_mark_val   = MARK_NONE;
		x_status     = ST_OK;
		x_granted    = '0;
		case (mode_s1) inside
			MODE_PROD_ACQ: begin
				if (free_empty) begin
					x_status = ST_NO_FREE;
				end else begin
					x_pop_free  = 1'b1;
					x_mark_we   = 1'b1;
					x_mark_addr = free_rd[IW-1:0];
					x_mark_val  = MARK_PROD;
					x_granted   = free_rd;
				end
			end
			MODE_COMMIT, MODE_CANCEL: begin
				if (!in_pool || mark_rd != MARK_PROD) begin
					x_status = ST_BAD_BUF;
				end else begin
					x_mark_we = 1'b1;
					if (mode_s1 == MODE_COMMIT)
						x_push_ready = !ready_full;
					else
						x_push_free = !free_full;
				end
			end
			MODE_CONS_ACQ: begin
				if (ready_empty) begin
					x_status = ST_NO_READY;
				end else begin
					x_pop_ready = 1'b1;
					x_mark_we   = 1'b1;
					x_mark_addr = ready_rd[IW-1:0];
					x_mark_val  = MARK_CONS;
					x_granted   = ready_rd;
				end
			end
			MODE_CONS_REL: begin
				if (!in_pool || mark_rd != MARK_CONS) begin
					x_status = ST_BAD_BUF;
				end else begin
					x_mark_we   = 1'b1;
					x_push_free = !free_full;
				end
			end
			default: x_status = ST_BAD_MODE;
		endcase
	end

	assign free_nxt  = free_fill + CW'(x_push_free) - CW'(x_pop_free);
	assign ready_nxt = ready_fill + CW'(x_push_ready) - CW'(x_pop_ready);

	assign free_ctl  = '{rd: acc, pop: go && x_pop_free, push: go && x_push_free};
	assign ready_ctl = '{rd: acc, pop: go && x_pop_ready, push: go && x_push_ready};

	always_comb begin
		if (in_init) begin
			mark_we    = 1'b1;
			mark_waddr = init_cnt_q;
			mark_wdata = MARK_NONE;
		end else begin
			mark_we    = go && x_mark_we;
			mark_waddr = x_mark_addr;
			mark_wdata = x_mark_val;
		end
	end

	bpom_queue #(
		.N(NUM_BUFFERS), .IW(IW), .CW(CW), .INIT_FULL(1'b1)
	) u_free_q (
		.clk(clk), .arst_n(arst_n),
		.init_we(in_init), .init_addr(init_cnt_q),
		.ctl(free_ctl), .push_id(id_s1),
		.rd_data(free_rd), .fill(free_fill),
		.empty(free_empty), .full(free_full)
	);

	bpom_queue #(
		.N(NUM_BUFFERS), .IW(IW), .CW(CW), .INIT_FULL(1'b0)
	) u_ready_q (
		.clk(clk), .arst_n(arst_n),
		.init_we(1'b0), .init_addr(init_cnt_q),
		.ctl(ready_ctl), .push_id(id_s1),
		.rd_data(ready_rd), .fill(ready_fill),
		.empty(ready_empty), .full(ready_full)
	);

	bpom_mark_mem #(
		.N(NUM_BUFFERS), .IW(IW)
	) u_mark (
		.clk(clk),
		.we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
		.re(acc), .raddr(req.buffer_id[IW-1:0]), .rdata(mark_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == IW'(NUM_BUFFERS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_INIT;
			endcase
			if (go)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= req.mode;
			id_s1   <= req.buffer_id;
		end
		if (go) begin
			status_q    <= x_status;
			granted_q   <= x_granted;
			free_cnt_q  <= CNT_W'(free_nxt);
			ready_cnt_q <= CNT_W'(ready_nxt);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.granted_id  = granted_q;
	assign rsp.free_count  = free_cnt_q;
	assign rsp.ready_count = ready_cnt_q;

	`BPOM_ASSERT_IMP(a_fill_sum, 1'b1, ((CW + 1)'(free_fill) + (CW + 1)'(ready_fill)) <= (CW + 1)'(NUM_BUFFERS), "ids lost or duplicated between queues")
	`BPOM_ASSERT_NXT(a_acc_exec, acc, state_q == S_EXEC, "accepted request not executed")
	`BPOM_ASSERT_IMP(a_load_exec, $rose(out_valid_q), $past(state_q == S_EXEC), "result appeared without execution")
	`BPOM_ASSERT_IMP(a_grant_pool, out_valid_q, {1'b0, granted_q} < (ID_W + 1)'(NUM_BUFFERS), "granted id outside pool")
	`BPOM_ASSERT_IMP(a_init_quiet, in_init, !out_valid_q, "result during start-up sweep")

endmodule
